/* rtl/core/fpbq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpbq_pkg
// Shared types and constants for the fixed-point biquad filter.
// ----------------------------------------------------------------------------
package fpbq_pkg;

  localparam int SAMPLE_W = 8;
  localparam int X_W      = 14;
  localparam int Y_W      = 16;
  localparam int PEAK_W   = 7;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_COEF = 5;

  localparam int IN_SHIFT_NORMAL = 6;
  localparam int IN_SHIFT_GAIN   = 2;
  localparam int OUT_SHIFT       = 6;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 8'sd127;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -8'sd128;
  localparam logic signed [Y_W-1:0]      Y_MAX      = 16'sd32767;
  localparam logic signed [Y_W-1:0]      Y_MIN      = -16'sd32768;
  localparam logic [PEAK_W-1:0]          PEAK_MAX   = 7'd127;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_B0          = 3'd0;
  localparam cfg_idx_t REG_B1          = 3'd1;
  localparam cfg_idx_t REG_B2          = 3'd2;
  localparam cfg_idx_t REG_A1          = 3'd3;
  localparam cfg_idx_t REG_A2          = 3'd4;
  localparam cfg_idx_t REG_GAIN_ADJUST = 3'd5;
  localparam cfg_idx_t REG_FILTER_ON   = 3'd6;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       table_start;
  } fpbq_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [PEAK_W-1:0]          peak_level;
  } fpbq_out_t;

  typedef struct packed {
    logic gain_adjust;
    logic filter_on;
    logic hist_clr;
  } fpbq_ctrl_t;

endpackage

/* rtl/core/fixed_point_biquad_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_biquad_filter
// Direct-form-I biquad on signed 8-bit wavetable samples with table peak.
//
// Input channel (in_valid/in_ready/in_data) takes one sample per transaction;
// the result channel (out_valid/out_ready/out_data) gives one sample, filtered
// or bypassed, and the running table peak per input transaction, in order.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready; a
// write to a listed register also clears the filter history. Write it only
// while no sample is in flight.
// A sample is taken into the input register and then moves into the output
// register, which drives out_data.
// Throughput: one sample per cycle while out_ready is high; the feedback path
// (five multipliers and the sum, shift and clamp) is combinational from the
// input and history registers to the output and history registers.
// When the receiver stalls, the output register holds and one more sample
// waits in the input register; in_ready then falls until out_ready returns.
// Reset clears coefficients, modes, history, peak and both valid flags.
// ----------------------------------------------------------------------------
module fixed_point_biquad_filter
  import fpbq_pkg::*;
#(
  parameter int COEF_WIDTH     = 24,
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fpbq_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fpbq_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_idx_t              cfg_index,
  input  logic [COEF_WIDTH-1:0] cfg_data
);

  logic                                s1_valid_r;
  fpbq_in_t                            s1_data_r;
  logic                                out_valid_r;
  fpbq_out_t                           out_data_r;
  logic                                advance, step;
  logic [NUM_COEF-1:0][COEF_WIDTH-1:0] coef;
  fpbq_ctrl_t                          ctrl;
  fpbq_out_t                           result;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign step      = s1_valid_r && advance;
  assign cfg_ready = 1'b1;

  fpbq_cfg_regs #(
    .COEF_WIDTH(COEF_WIDTH)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .coef     (coef),
    .ctrl     (ctrl)
  );

  fpbq_datapath #(
    .COEF_WIDTH    (COEF_WIDTH),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (s1_data_r),
    .ctrl  (ctrl),
    .coef  (coef),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (step) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/core/fpbq_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpbq_cfg_regs
// Coef and mode registers; valid writes to index 0-6 flag a history clear.
// ----------------------------------------------------------------------------
module fpbq_cfg_regs
  import fpbq_pkg::*;
#(
  parameter int COEF_WIDTH = 24
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      cfg_valid,
  input  cfg_idx_t                                  cfg_index,
  input  logic [COEF_WIDTH-1:0]                     cfg_data,
  output logic [NUM_COEF-1:0][COEF_WIDTH-1:0]       coef,
  output fpbq_ctrl_t                                ctrl
);

  logic [NUM_COEF-1:0][COEF_WIDTH-1:0] coef_r, coef_nxt;
  logic gain_adjust_r, gain_adjust_nxt;
  logic filter_on_r, filter_on_nxt;

  always_comb begin
    coef_nxt        = coef_r;
    gain_adjust_nxt = gain_adjust_r;
    filter_on_nxt   = filter_on_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_B0:          coef_nxt[0] = cfg_data;
        REG_B1:          coef_nxt[1] = cfg_data;
        REG_B2:          coef_nxt[2] = cfg_data;
        REG_A1:          coef_nxt[3] = cfg_data;
        REG_A2:          coef_nxt[4] = cfg_data;
        REG_GAIN_ADJUST: gain_adjust_nxt = cfg_data[0];
        REG_FILTER_ON:   filter_on_nxt = cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r        <= '0;
      gain_adjust_r <= 1'b0;
      filter_on_r   <= 1'b0;
    end else begin
      coef_r        <= coef_nxt;
      gain_adjust_r <= gain_adjust_nxt;
      filter_on_r   <= filter_on_nxt;
    end
  end

  assign coef             = coef_r;
  assign ctrl.gain_adjust = gain_adjust_r;
  assign ctrl.filter_on   = filter_on_r;
  assign ctrl.hist_clr    = cfg_valid && (cfg_index inside {[REG_B0:REG_FILTER_ON]});

endmodule

/* rtl/core/fpbq_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpbq_datapath
// Direct-form-I biquad arithmetic, filter history and running table peak.
// ----------------------------------------------------------------------------
module fpbq_datapath
  import fpbq_pkg::*;
#(
  parameter int COEF_WIDTH     = 24,
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  fpbq_in_t                            item,
  input  fpbq_ctrl_t                          ctrl,
  input  logic [NUM_COEF-1:0][COEF_WIDTH-1:0] coef,
  output fpbq_out_t                           result
);

  localparam int PROD_W = COEF_WIDTH + Y_W;
  localparam int ACC_W  = PROD_W + 3;

  logic signed [X_W-1:0]    x1_r, x2_r;
  logic signed [Y_W-1:0]    y1_r, y2_r;
  logic [PEAK_W-1:0]        peak_r, peak_nxt;

  logic signed [X_W-1:0]    x_ext, x0;
  logic signed [Y_W-1:0]    x0_w, x1_w, x2_w;
  logic signed [COEF_WIDTH-1:0] c_b0, c_b1, c_b2, c_a1, c_a2;
  logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [ACC_W-1:0]  acc, acc_sh;
  logic signed [Y_W-1:0]    y0, y0_sh;
  logic signed [SAMPLE_W-1:0] s_out, s_neg;
  logic [PEAK_W-1:0]        mag, peak_base;

  // input scaling
  assign x_ext = {{(X_W-SAMPLE_W){item.sample_in[SAMPLE_W-1]}}, item.sample_in};
  assign x0    = ctrl.gain_adjust ? (x_ext <<< IN_SHIFT_GAIN) : (x_ext <<< IN_SHIFT_NORMAL);

  assign x0_w = {{(Y_W-X_W){x0[X_W-1]}}, x0};
  assign x1_w = {{(Y_W-X_W){x1_r[X_W-1]}}, x1_r};
  assign x2_w = {{(Y_W-X_W){x2_r[X_W-1]}}, x2_r};

  assign c_b0 = coef[0];
  assign c_b1 = coef[1];
  assign c_b2 = coef[2];
  assign c_a1 = coef[3];
  assign c_a2 = coef[4];

  // five parallel products
  assign p_b0 = c_b0 * x0_w;
  assign p_b1 = c_b1 * x1_w;
  assign p_b2 = c_b2 * x2_w;
  assign p_a1 = c_a1 * y1_r;
  assign p_a2 = c_a2 * y2_r;

  assign acc = {{3{p_b0[PROD_W-1]}}, p_b0} + {{3{p_b1[PROD_W-1]}}, p_b1}
             + {{3{p_b2[PROD_W-1]}}, p_b2} - {{3{p_a1[PROD_W-1]}}, p_a1}
             - {{3{p_a2[PROD_W-1]}}, p_a2};

  // floor shift and clamp to 16 bits
  assign acc_sh = acc >>> COEF_FRAC_BITS;
  always_comb begin
    if (acc_sh[ACC_W-1:Y_W-1] == {(ACC_W-Y_W+1){acc_sh[Y_W-1]}}) begin
      y0 = acc_sh[Y_W-1:0];
    end else if (acc_sh[ACC_W-1]) begin
      y0 = Y_MIN;
    end else begin
      y0 = Y_MAX;
    end
  end

  // output scaling and clamp to 8 bits
  assign y0_sh = y0 >>> OUT_SHIFT;
  always_comb begin
    if (y0_sh[Y_W-1:SAMPLE_W-1] == {(Y_W-SAMPLE_W+1){y0_sh[SAMPLE_W-1]}}) begin
      s_out = y0_sh[SAMPLE_W-1:0];
    end else if (y0_sh[Y_W-1]) begin
      s_out = SAMPLE_MIN;
    end else begin
      s_out = SAMPLE_MAX;
    end
  end

  // magnitude, with the most negative sample counted as full scale
  assign s_neg = -s_out;
  always_comb begin
    if (s_out == SAMPLE_MIN) begin
      mag = PEAK_MAX;
    end else if (s_out[SAMPLE_W-1]) begin
      mag = s_neg[PEAK_W-1:0];
    end else begin
      mag = s_out[PEAK_W-1:0];
    end
  end

  assign peak_base = item.table_start ? '0 : peak_r;
  assign peak_nxt  = (ctrl.filter_on && (mag > peak_base)) ? mag : peak_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r   <= '0;
      x2_r   <= '0;
      y1_r   <= '0;
      y2_r   <= '0;
      peak_r <= '0;
    end else begin
      if (ctrl.hist_clr) begin
        x1_r <= '0;
        x2_r <= '0;
        y1_r <= '0;
        y2_r <= '0;
      end else if (step && ctrl.filter_on) begin
        x1_r <= x0;
        x2_r <= x1_r;
        y1_r <= y0;
        y2_r <= y1_r;
      end
      if (step) begin
        peak_r <= peak_nxt;
      end
    end
  end

  assign result.sample_out = ctrl.filter_on ? s_out : item.sample_in;
  assign result.peak_level = peak_nxt;

endmodule

/* rtl/core/fpbq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpbq_checker
// Port-level checks on the biquad filter's channels, bound to the top level.
// ----------------------------------------------------------------------------
module fpbq_checker
  import fpbq_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input fpbq_out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // empty output side never blocks input
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // accepted sample reaches the output once the pipe moves
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready ##1 (!out_valid || out_ready) |=> out_valid)
    else $error("accepted transaction did not reach output");

  // nothing on the output right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind fixed_point_biquad_filter fpbq_checker u_fpbq_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
